// ===== sv/bam_pkg.sv =====
// Package: types and constants shared by the block average mosaic design.
package bam_pkg;

   localparam int MAX_FRAME_WIDTH_DEF  = 1024;
   localparam int MAX_FRAME_HEIGHT_DEF = 1024;
   localparam int MAX_TILE_DEF         = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_TILE_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam int HUE_SUM_W   = 27;
   localparam int SMALL_SUM_W = 20;

   typedef struct packed {
      logic        start_of_frame;
      logic [14:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  luminance;
      logic [7:0]  alpha;
   } req_beat_type;

   typedef struct packed {
      logic [9:0]  tile_column;
      logic [9:0]  tile_row;
      logic [14:0] mean_hue;
      logic [7:0]  mean_saturation;
      logic [7:0]  mean_luminance;
      logic [7:0]  mean_alpha;
   } rsp_beat_type;

   // Sums of one tile column, handed to the divider.
   typedef struct packed {
      logic [9:0]             tile_column;
      logic [9:0]             tile_row;
      logic [HUE_SUM_W-1:0]   hue;
      logic [SMALL_SUM_W-1:0] sat;
      logic [SMALL_SUM_W-1:0] lum;
      logic [SMALL_SUM_W-1:0] alp;
      logic [12:0]            count;
   } bam_sums_type;

endpackage

// ===== sv/bam_divider.sv =====
// Bit-serial restoring divider for the four channel means of one tile.
module bam_divider
   import bam_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  bam_sums_type sums,
   output logic         done,
   output rsp_beat_type result
);

   localparam int STEPS = HUE_SUM_W;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [4:0]             step_ff, step_in;
   bam_sums_type           q_ff, q_in;
   logic [12:0]            rh_ff, rh_in, rs_ff, rs_in, rl_ff, rl_in, ra_ff, ra_in;

   logic [13:0] sh_h, sh_s, sh_l, sh_a;
   logic        ge_h, ge_s, ge_l, ge_a;

   always_comb begin
      sh_h = {rh_ff, q_ff.hue[HUE_SUM_W-1]};
      sh_s = {rs_ff, q_ff.sat[SMALL_SUM_W-1]};
      sh_l = {rl_ff, q_ff.lum[SMALL_SUM_W-1]};
      sh_a = {ra_ff, q_ff.alp[SMALL_SUM_W-1]};
      ge_h = sh_h >= {1'b0, q_ff.count};
      ge_s = (step_ff < 5'(STEPS - SMALL_SUM_W)) ? 1'b0 : sh_s >= {1'b0, q_ff.count};
      ge_l = (step_ff < 5'(STEPS - SMALL_SUM_W)) ? 1'b0 : sh_l >= {1'b0, q_ff.count};
      ge_a = (step_ff < 5'(STEPS - SMALL_SUM_W)) ? 1'b0 : sh_a >= {1'b0, q_ff.count};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      q_in    = q_ff;
      rh_in   = rh_ff;
      rs_in   = rs_ff;
      rl_in   = rl_ff;
      ra_in   = ra_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         q_in    = sums;
         rh_in   = '0;
         rs_in   = '0;
         rl_in   = '0;
         ra_in   = '0;
      end else if (busy_ff) begin
         // hue walks all its bits; the 20-bit sums join for the final bits
         rh_in = ge_h ? 13'(sh_h - {1'b0, q_ff.count}) : sh_h[12:0];
         q_in.hue = {q_ff.hue[HUE_SUM_W-2:0], ge_h};
         if (step_ff >= 5'(STEPS - SMALL_SUM_W)) begin
            rs_in = ge_s ? 13'(sh_s - {1'b0, q_ff.count}) : sh_s[12:0];
            rl_in = ge_l ? 13'(sh_l - {1'b0, q_ff.count}) : sh_l[12:0];
            ra_in = ge_a ? 13'(sh_a - {1'b0, q_ff.count}) : sh_a[12:0];
            q_in.sat = {q_ff.sat[SMALL_SUM_W-2:0], ge_s};
            q_in.lum = {q_ff.lum[SMALL_SUM_W-2:0], ge_l};
            q_in.alp = {q_ff.alp[SMALL_SUM_W-2:0], ge_a};
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      q_ff  <= q_in;
      rh_ff <= rh_in;
      rs_ff <= rs_in;
      rl_ff <= rl_in;
      ra_ff <= ra_in;
   end

   assign done = done_ff;
   assign result.tile_column     = q_ff.tile_column;
   assign result.tile_row        = q_ff.tile_row;
   assign result.mean_hue        = q_ff.hue[14:0];
   assign result.mean_saturation = q_ff.sat[7:0];
   assign result.mean_luminance  = q_ff.lum[7:0];
   assign result.mean_alpha      = q_ff.alp[7:0];

endmodule

// ===== sv/block_average_mosaic_top.sv =====
// Top level of the block average mosaic: column-sum memory, tile tracking, output.
//
//  channel | ports                              | beat
//  --------+------------------------------------+------------------------------
//  req     | req_valid, req_stall, req_beat     | one HSLA pixel, raster order
//  rsp     | rsp_valid, rsp_stall, rsp_beat     | one finished tile mean
//  csr     | csr_write, csr_index, csr_data     | tile size, frame width/height
//
// A pixel that closes no tile passes through accept, memory read and write back.
// A pixel that closes a tile then runs the bit-serial divider (27 quotient steps and
// the done flag) and one more state to load the output register.
// The first pixel after a register write first runs ST_ALIGN, where the in-tile
// position is rebuilt by a 10-step division of the column and row by the tile size.
// After reset a clearing pass sweeps all MAX_FRAME_WIDTH entries of the sums memory,
// with req_stall held high. A start-of-frame beat runs the same sweep first.
// A finished tile waits in the output register; the next pixel is taken
// meanwhile, and only a second finished tile waits on rsp_stall.
module block_average_mosaic_top
   import bam_pkg::*;
#(
   parameter int MAX_FRAME_WIDTH  = MAX_FRAME_WIDTH_DEF,
   parameter int MAX_FRAME_HEIGHT = MAX_FRAME_HEIGHT_DEF,
   parameter int MAX_TILE         = MAX_TILE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_beat_type          req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_beat_type          rsp_beat,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = (MAX_FRAME_WIDTH > 1) ? $clog2(MAX_FRAME_WIDTH) : 1;
   localparam int PW = 13;   // position / size arithmetic width
   localparam int ENTRY_W = HUE_SUM_W + 3 * SMALL_SUM_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;
   localparam logic [2:0] ST_ALIGN = 3'd6;

   logic [6:0]  tile_size_ff;
   logic [10:0] frame_width_ff, frame_height_ff;
   logic [2:0]  state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [9:0]  col_ff, col_in, row_ff, row_in;
   // position inside the current tile, tracked instead of dividing
   logic [PW-1:0] xin_ff, xin_in, yin_ff, yin_in, tc_ff, tc_in, tr_ff, tr_in;
   req_beat_type  pix_ff, pix_in;
   logic          last_ff, last_in;
   logic [PW-1:0] tile_cnt_ff, tile_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type  rsp_beat_ff, rsp_beat_in;
   // rebuild of the tracked position after a register write
   logic          realign_ff, realign_in;
   logic [3:0]    aln_step_ff, aln_step_in;
   logic [9:0]    qx_ff, qx_in, qy_ff, qy_in;
   logic [6:0]    rx_ff, rx_in, ry_ff, ry_in;
   logic [7:0]    shx, shy;
   logic          gex, gey;
   logic [6:0]    rx_nx, ry_nx;
   logic [9:0]    qx_nx, qy_nx;

   logic [ENTRY_W-1:0] mem [MAX_FRAME_WIDTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [PW-1:0] ts, fw, fh, x, y, xi, yi, tcol, trow, tw, th;
   logic          lc, lr, wrap_x;

   bam_sums_type div_sums;
   logic         div_start, div_done;
   rsp_beat_type div_result;

   bam_divider u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .sums   (div_sums),
      .done   (div_done),
      .result (div_result)
   );

   // effective register values
   always_comb begin
      ts = (tile_size_ff == '0) ? PW'(1) :
           (PW'(tile_size_ff) > PW'(MAX_TILE)) ? PW'(MAX_TILE) : PW'(tile_size_ff);
      fw = (frame_width_ff == '0) ? PW'(1) :
           (PW'(frame_width_ff) > PW'(MAX_FRAME_WIDTH)) ? PW'(MAX_FRAME_WIDTH)
                                                       : PW'(frame_width_ff);
      fh = (frame_height_ff == '0) ? PW'(1) :
           (PW'(frame_height_ff) > PW'(MAX_FRAME_HEIGHT)) ? PW'(MAX_FRAME_HEIGHT)
                                                         : PW'(frame_height_ff);
   end

   // position of the pixel held in pix_ff, with out-of-frame wrap
   always_comb begin
      x    = (PW'(col_ff) < fw) ? PW'(col_ff) : '0;
      y    = (PW'(row_ff) < fh) ? PW'(row_ff) : '0;
      xi   = (PW'(col_ff) < fw && xin_ff < ts) ? xin_ff : '0;
      tcol = (PW'(col_ff) < fw && xin_ff < ts) ? tc_ff : '0;
      yi   = (PW'(row_ff) < fh && yin_ff < ts) ? yin_ff : '0;
      trow = (PW'(row_ff) < fh && yin_ff < ts) ? tr_ff : '0;
      lc   = (xi == ts - PW'(1)) || (x == fw - PW'(1));
      lr   = (yi == ts - PW'(1)) || (y == fh - PW'(1));
      wrap_x = (x == fw - PW'(1));
      tw   = xi + PW'(1);
      th   = yi + PW'(1);
   end

   // one restoring step each for column and row divided by the tile size
   always_comb begin
      shx   = {rx_ff, qx_ff[9]};
      shy   = {ry_ff, qy_ff[9]};
      gex   = shx >= 8'(ts);
      gey   = shy >= 8'(ts);
      rx_nx = gex ? 7'(shx - 8'(ts)) : shx[6:0];
      ry_nx = gey ? 7'(shy - 8'(ts)) : shy[6:0];
      qx_nx = {qx_ff[8:0], gex};
      qy_nx = {qy_ff[8:0], gey};
   end

   assign rd_addr = AW'(tcol);

   always_comb begin
      logic [HUE_SUM_W-1:0]   h;
      logic [SMALL_SUM_W-1:0] s, l, a;
      h = rd_data_ff[ENTRY_W-1 -: HUE_SUM_W] + HUE_SUM_W'(pix_ff.hue);
      s = rd_data_ff[3*SMALL_SUM_W-1 -: SMALL_SUM_W] + SMALL_SUM_W'(pix_ff.saturation);
      l = rd_data_ff[2*SMALL_SUM_W-1 -: SMALL_SUM_W] + SMALL_SUM_W'(pix_ff.luminance);
      a = rd_data_ff[SMALL_SUM_W-1:0] + SMALL_SUM_W'(pix_ff.alpha);
      div_sums.tile_column = tcol[9:0];
      div_sums.tile_row    = trow[9:0];
      div_sums.hue   = h;
      div_sums.sat   = s;
      div_sums.lum   = l;
      div_sums.alp   = a;
      div_sums.count = tile_cnt_ff;

      wr_en   = 1'b0;
      wr_addr = rd_addr;
      wr_data = {h, s, l, a};
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         wr_en = 1'b1;
         if (last_ff)
            wr_data = '0;
      end
   end

   assign div_start = (state_ff == ST_WRITE) && last_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      xin_in       = xin_ff;
      yin_in       = yin_ff;
      tc_in        = tc_ff;
      tr_in        = tr_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      tile_cnt_in  = tile_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_beat_in  = rsp_beat_ff;
      realign_in   = realign_ff;
      aln_step_in  = aln_step_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MAX_FRAME_WIDTH - 1))
               state_in = pix_ff.start_of_frame ? ST_READ : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               pix_in = req_beat;
               if (req_beat.start_of_frame) begin
                  col_in     = '0;
                  row_in     = '0;
                  xin_in     = '0;
                  yin_in     = '0;
                  tc_in      = '0;
                  tr_in      = '0;
                  clr_in     = '0;
                  realign_in = 1'b0;
                  state_in   = ST_CLEAR;
               end else if (realign_ff) begin
                  // registers changed: rebuild tile index and in-tile offset
                  qx_in       = x[9:0];
                  qy_in       = y[9:0];
                  rx_in       = '0;
                  ry_in       = '0;
                  aln_step_in = '0;
                  realign_in  = 1'b0;
                  state_in    = ST_ALIGN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_ALIGN: begin
            qx_in       = qx_nx;
            qy_in       = qy_nx;
            rx_in       = rx_nx;
            ry_in       = ry_nx;
            aln_step_in = aln_step_ff + 4'd1;
            if (aln_step_ff == 4'd9) begin
               xin_in   = PW'(rx_nx);
               tc_in    = PW'(qx_nx);
               yin_in   = PW'(ry_nx);
               tr_in    = PW'(qy_nx);
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in    = ST_WRITE;
            last_in     = lc && lr;
            tile_cnt_in = PW'(tw * th);
         end
         ST_WRITE: begin
            // commit the wrapped position and advance
            if (wrap_x) begin
               col_in = '0;
               xin_in = '0;
               tc_in  = '0;
               if (y == fh - PW'(1)) begin
                  row_in = '0;
                  yin_in = '0;
                  tr_in  = '0;
               end else begin
                  row_in = 10'(y + PW'(1));
                  yin_in = (yi == ts - PW'(1)) ? '0 : yi + PW'(1);
                  tr_in  = (yi == ts - PW'(1)) ? trow + PW'(1) : trow;
               end
            end else begin
               col_in = 10'(x + PW'(1));
               row_in = 10'(y);
               xin_in = (xi == ts - PW'(1)) ? '0 : xi + PW'(1);
               tc_in  = (xi == ts - PW'(1)) ? tcol + PW'(1) : tcol;
               yin_in = yi;
               tr_in  = trow;
            end
            state_in = last_ff ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (div_done)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_beat_in  = div_result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write)
         realign_in = 1'b1;
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_size_ff    <= 7'd8;
         frame_width_ff  <= 11'd640;
         frame_height_ff <= 11'd480;
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         xin_ff          <= '0;
         yin_ff          <= '0;
         tc_ff           <= '0;
         tr_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
         last_ff         <= 1'b0;
         realign_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TILE_SIZE:    tile_size_ff    <= csr_data[6:0];
               CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
               CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
               default: ;
            endcase
         end
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         xin_ff       <= xin_in;
         yin_ff       <= yin_in;
         tc_ff        <= tc_in;
         tr_ff        <= tr_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         realign_ff   <= realign_in;
      end
      pix_ff      <= (reset) ? '0 : pix_in;
      tile_cnt_ff <= tile_cnt_in;
      rsp_beat_ff <= rsp_beat_in;
      aln_step_ff <= aln_step_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
   end

   // sums memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ===== sv/bam_checker.sv =====
// Port-level checker for the block average mosaic, bound to the top level.
module bam_checker
   import bam_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_beat_type rsp_beat
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("rsp beat changed under stall");

   // an accepted pixel is never followed by a back-to-back accept
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("pixel accepted back to back");

   // a result never appears in the cycle after a pixel accept
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

   // reset leaves the input stalled for the clearing sweep
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("input open during clearing pass");

endmodule

bind block_average_mosaic_top bam_checker u_bam_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);
